// ===== hw/rtl/rnpi_pkg.sv =====
`default_nettype none
package rnpi_pkg;

  typedef logic [9:0] dist_t;
  localparam dist_t DIST_NONE = 10'h3ff;

  typedef struct packed {
    logic [7:0] idx;
    dist_t      d;
  } best_t;

  typedef struct packed {
    logic [2:0] l;
    logic [8:0] d;
  } lvl_t;

  // One cube candidate: chosen level and distance for each channel
  typedef struct packed {
    logic       ok;
    logic [2:0] lr;
    logic [2:0] lg;
    logic [2:0] lb;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
  } cand_t;

  localparam int SYS_ENTRIES  = 16;
  localparam int GRAY_ENTRIES = 24;
  localparam int CUBE_BASE    = 16;
  localparam int GRAY_BASE    = 232;

  function automatic logic [23:0] sys_rgb(input logic [3:0] i);
    logic [23:0] c;
    case (i)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h800000;
      4'd2:    c = 24'h008000;
      4'd3:    c = 24'h808000;
      4'd4:    c = 24'h000080;
      4'd5:    c = 24'h800080;
      4'd6:    c = 24'h008080;
      4'd7:    c = 24'hc0c0c0;
      4'd8:    c = 24'h808080;
      4'd9:    c = 24'hff0000;
      4'd10:   c = 24'h00ff00;
      4'd11:   c = 24'hffff00;
      4'd12:   c = 24'h0000ff;
      4'd13:   c = 24'hff00ff;
      4'd14:   c = 24'h00ffff;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] l);
    logic [7:0] v;
    case (l)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h5f;
      3'd2:    v = 8'h87;
      3'd3:    v = 8'haf;
      3'd4:    v = 8'hd7;
      3'd5:    v = 8'hff;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] absd8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Nearest of the first n cube levels, lowest level on a tie
  function automatic lvl_t best_lvl(input logic [7:0] v, input int n);
    lvl_t       r;
    logic [7:0] ad;
    r.l = 3'd0;
    r.d = 9'h1ff;
    for (int j = 0; j < 6; j++) begin
      ad = absd8(v, cube_level(3'(j)));
      if (j < n && {1'b0, ad} < r.d) begin
        r.l = 3'(j);
        r.d = {1'b0, ad};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rnpi_dist.sv =====
`default_nettype none
module rnpi_dist
  import rnpi_pkg::*;
#(
  parameter int SYS_N  = 16,
  parameter int GRAY_N = 24,
  parameter int A0     = 6,
  parameter int B0     = 0,
  parameter int C0     = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_valid,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            out_valid,
  output dist_t           sys_d [SYS_ENTRIES],
  output dist_t           gray_d [GRAY_ENTRIES],
  output cand_t           cand [3]
);

  dist_t sys_d_next  [SYS_ENTRIES];
  dist_t gray_d_next [GRAY_ENTRIES];
  cand_t cand_next   [3];

  // Distance to every searched system colour and grey; entries beyond the search read DIST_NONE
  always_comb begin
    logic [23:0] c;
    logic [7:0]  k;
    for (int i = 0; i < SYS_ENTRIES; i++) begin
      c = sys_rgb(4'(i));
      if (i < SYS_N)
        sys_d_next[i] = 10'(absd8(c[23:16], red)) + 10'(absd8(c[15:8], green))
                      + 10'(absd8(c[7:0], blue));
      else
        sys_d_next[i] = DIST_NONE;
    end
    for (int g = 0; g < GRAY_ENTRIES; g++) begin
      k = 8'(8 + 10 * g);
      if (g < GRAY_N)
        gray_d_next[g] = 10'(absd8(k, red)) + 10'(absd8(k, green))
                       + 10'(absd8(k, blue));
      else
        gray_d_next[g] = DIST_NONE;
    end
  end

  // Cube candidates per channel over the searched prefix of the cube
  always_comb begin
    lvl_t lr, lg, lb;
    lr = best_lvl(red, A0);
    lg = best_lvl(green, 6);
    lb = best_lvl(blue, 6);
    cand_next[0] = '{ok: (A0 > 0), lr: lr.l, lg: lg.l, lb: lb.l,
                     dr: lr.d[7:0], dg: lg.d[7:0], db: lb.d[7:0]};
    lg = best_lvl(green, B0);
    cand_next[1] = '{ok: (B0 > 0), lr: 3'(A0), lg: lg.l, lb: lb.l,
                     dr: absd8(red, cube_level(3'(A0))), dg: lg.d[7:0], db: lb.d[7:0]};
    lb = best_lvl(blue, C0);
    cand_next[2] = '{ok: (C0 > 0), lr: 3'(A0), lg: 3'(B0), lb: lb.l,
                     dr: absd8(red, cube_level(3'(A0))),
                     dg: absd8(green, cube_level(3'(B0))), db: lb.d[7:0]};
  end

  // Advance stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      sys_d  <= sys_d_next;
      gray_d <= gray_d_next;
      cand   <= cand_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rnpi_reduce.sv =====
`default_nettype none
module rnpi_reduce
  import rnpi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  dist_t     sys_d [SYS_ENTRIES],
  input  dist_t     gray_d [GRAY_ENTRIES],
  input  cand_t     cand [3],
  output logic      out_valid,
  output best_t     sys_best,
  output best_t     cube_best,
  output best_t     gray_best
);

  logic  v2;
  best_t sys2 [4];
  best_t gray2 [6];
  best_t cube2;
  best_t sys2_next [4];
  best_t gray2_next [6];
  best_t cube2_next;
  best_t sys3_next, gray3_next;

  // First tree level: groups of four, lowest index kept on a tie; the cube candidates are merged here too
  always_comb begin
    dist_t d;
    for (int q = 0; q < 4; q++) begin
      sys2_next[q] = '{idx: 8'(4 * q), d: sys_d[4 * q]};
      for (int j = 1; j < 4; j++)
        if (sys_d[4 * q + j] < sys2_next[q].d)
          sys2_next[q] = '{idx: 8'(4 * q + j), d: sys_d[4 * q + j]};
    end
    for (int q = 0; q < 6; q++) begin
      gray2_next[q] = '{idx: 8'(GRAY_BASE + 4 * q), d: gray_d[4 * q]};
      for (int j = 1; j < 4; j++)
        if (gray_d[4 * q + j] < gray2_next[q].d)
          gray2_next[q] = '{idx: 8'(GRAY_BASE + 4 * q + j), d: gray_d[4 * q + j]};
    end
    cube2_next = '{idx: 8'(CUBE_BASE), d: DIST_NONE};
    for (int k = 0; k < 3; k++) begin
      d = 10'(cand[k].dr) + 10'(cand[k].dg) + 10'(cand[k].db);
      if (cand[k].ok && d < cube2_next.d)
        cube2_next = '{idx: 8'(CUBE_BASE) + 8'(cand[k].lr) * 8'd36
                          + 8'(cand[k].lg) * 8'd6 + 8'(cand[k].lb), d: d};
    end
  end

  // Second tree level
  always_comb begin
    sys3_next = sys2[0];
    for (int q = 1; q < 4; q++)
      if (sys2[q].d < sys3_next.d) sys3_next = sys2[q];
    gray3_next = gray2[0];
    for (int q = 1; q < 6; q++)
      if (gray2[q].d < gray3_next.d) gray3_next = gray2[q];
  end

  // Advance stages two and three
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= in_valid;
      out_valid <= v2;
    end
    if (en) begin
      sys2      <= sys2_next;
      gray2     <= gray2_next;
      cube2     <= cube2_next;
      sys_best  <= sys3_next;
      gray_best <= gray3_next;
      cube_best <= cube2;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_nearest_palette_index.sv =====
`default_nettype none
// Nearest-colour lookup in the 256-entry terminal palette (16 system colours,
// 6x6x6 cube, 24 greys) under the sum of absolute channel differences; the
// lowest index wins a tie. Four register stages: channel distances, two levels
// of a minimum tree, and the output register behind the three-way merge. One
// pixel is taken every clock while the output is not stalled; the result is
// presented from the output register. Any stall of the output holds the whole
// pipeline. PALETTE_ENTRIES limits the search to the first entries.
module rgb_nearest_palette_index
  import rnpi_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // palette_index[7:0]
);

  localparam int P      = (PALETTE_ENTRIES > 256) ? 256 :
                          ((PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES);
  localparam int SYS_N  = (P < 16) ? P : 16;
  localparam int CUBE_N = (P <= 16) ? 0 : ((P >= 232) ? 216 : P - 16);
  localparam int GRAY_N = (P > 232) ? P - 232 : 0;
  localparam int A0     = CUBE_N / 36;
  localparam int B0     = (CUBE_N % 36) / 6;
  localparam int C0     = CUBE_N % 6;

  logic  en;
  logic  v1, v3;
  dist_t sys_d [SYS_ENTRIES];
  dist_t gray_d [GRAY_ENTRIES];
  cand_t cand [3];
  best_t sys_best, cube_best, gray_best;
  best_t pick;

  // Hold every stage while the result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rnpi_dist #(
    .SYS_N (SYS_N),
    .GRAY_N(GRAY_N),
    .A0    (A0),
    .B0    (B0),
    .C0    (C0)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .red      (s_tdata[7:0]),
    .green    (s_tdata[15:8]),
    .blue     (s_tdata[23:16]),
    .out_valid(v1),
    .sys_d    (sys_d),
    .gray_d   (gray_d),
    .cand     (cand)
  );

  rnpi_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .sys_d    (sys_d),
    .gray_d   (gray_d),
    .cand     (cand),
    .out_valid(v3),
    .sys_best (sys_best),
    .cube_best(cube_best),
    .gray_best(gray_best)
  );

  // Merge the groups in index order
  always_comb begin
    pick = sys_best;
    if (cube_best.d < pick.d) pick = cube_best;
    if (gray_best.d < pick.d) pick = gray_best;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v3;
    end
    if (en) begin
      m_tdata <= pick.idx;
    end
  end

endmodule
`default_nettype wire
